@@ sv/drum_strike_detector_assert.svh @@
// ----------------------------------------------------------------------------
// drum_strike_detector_assert.svh
// assertion macros shared by dsd_frame_acc and dsd_strike
// ----------------------------------------------------------------------------
`ifndef DRUM_STRIKE_DETECTOR_ASSERT_SVH
`define DRUM_STRIKE_DETECTOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define DSD_ASSERT_SAME_CYCLE(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("strike detector check failed");

// condition holds in the cycle after the trigger
`define DSD_ASSERT_NEXT_CYCLE(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("strike detector check failed");

`endif

@@ sv/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsd_pkg
// shared types, constants and calibration tables of the strike detector
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int NUM_CH = 5;
    localparam int CH_W = $clog2(NUM_CH);

    localparam int CH_TOP = 0;
    localparam int CH_BOTTOM = 1;
    localparam int CH_LEFT = 2;
    localparam int CH_RIGHT = 3;
    localparam int CH_FORCE = 4;

    localparam int SAMPLES_PER_CHANNEL_DEF = 5;
    localparam int SAMPLE_BITS_DEF = 8;

    localparam int TIME_W = 32;
    localparam int CAL_W = 9;
    localparam int LEVEL_W = 8;
    localparam int GAIN_W = 18;
    localparam int OFFS_W = 25;
    localparam int Q16_SHIFT = 16;
    localparam int Q16_BIAS = 65535;

    localparam logic signed [CAL_W-1:0] CAL_MAX = 9'sh0FF;
    localparam logic signed [CAL_W-1:0] CAL_MIN = 9'sh100;

    // register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD = 2'd3;

    localparam int FLOOR_W = 8;
    localparam int RISE_W = 8;
    localparam int HOLDOFF_W = 16;
    localparam int PERIOD_W = 11;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 8'd12;
    localparam logic [RISE_W-1:0] RISE_RESET = 8'd10;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd60;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd1000;

    // per channel gain and offset in q16
    localparam logic signed [GAIN_W-1:0] GAIN_Q16 [NUM_CH] = '{
        18'sd53600, 18'sd50052, 18'sd68556, 18'sd61897, -18'sd12329
    };
    localparam logic signed [OFFS_W-1:0] OFFS_Q16 [NUM_CH] = '{
        25'sd6334919, 25'sd5975831, 25'sd8122593, 25'sd7455369, -25'sd1343121
    };

    typedef struct packed {
        logic [FLOOR_W-1:0]   floor_level;
        logic [RISE_W-1:0]    rise_threshold;
        logic [HOLDOFF_W-1:0] holdoff_ticks;
        logic [PERIOD_W-1:0]  beat_period;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic [TIME_W-1:0] elapsed;
    } frame_time_t;

    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic              early_side;
        logic [TIME_W-1:0] beat_offset;
    } beat_info_t;

    function automatic int sum_width(int spc, int sb);
        return $clog2(spc * ((1 << sb) - 1) + 1);
    endfunction

endpackage

@@ sv/dsd_in_if.sv @@
// ----------------------------------------------------------------------------
// dsd_in_if
// sample stream channel into the strike detector
// ----------------------------------------------------------------------------
interface dsd_in_if
    import dsd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic [TIME_W-1:0]      sample_time;
    logic [TIME_W-1:0]      last_beat_time;

    modport source (output valid, output raw_sample, output sample_time,
                    output last_beat_time, input ready);
    modport sink (input valid, input raw_sample, input sample_time,
                  input last_beat_time, output ready);
endinterface

@@ sv/dsd_out_if.sv @@
// ----------------------------------------------------------------------------
// dsd_out_if
// per frame result channel out of the strike detector
// ----------------------------------------------------------------------------
interface dsd_out_if
    import dsd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [CAL_W-1:0]  top;
    logic signed [CAL_W-1:0]  bottom;
    logic signed [CAL_W-1:0]  left;
    logic signed [CAL_W-1:0]  right;
    logic signed [CAL_W-1:0]  force_res;
    logic [LEVEL_W-1:0]       level;
    logic                     strike;
    logic                     early;
    logic [TIME_W-1:0]        time_offset;

    modport source (output valid, output top, output bottom, output left,
                    output right, output force_res, output level, output strike,
                    output early, output time_offset, input ready);
    modport sink (input valid, input top, input bottom, input left, input right,
                  input force_res, input level, input strike, input early,
                  input time_offset, output ready);
endinterface

@@ sv/dsd_frame_acc.sv @@
// ----------------------------------------------------------------------------
// dsd_frame_acc
// per channel sample accumulation, hands over channel sums at frame end
// ----------------------------------------------------------------------------
`include "drum_strike_detector_assert.svh"

module dsd_frame_acc
    import dsd_pkg::*;
#(
    parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int SUM_W = sum_width(SAMPLES_PER_CHANNEL, SAMPLE_BITS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_W-1:0]      sample_time,
    input  logic [TIME_W-1:0]      last_beat_time,
    output logic                   frame_valid,
    input  logic                   frame_ready,
    output logic [SUM_W-1:0]       frame_sums [NUM_CH],
    output frame_time_t            frame_time
);

    localparam int FRAME_LEN = NUM_CH * SAMPLES_PER_CHANNEL;
    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

    logic [POS_W-1:0] pos_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [SUM_W-1:0] sums_reg [NUM_CH];
    logic             frame_valid_reg;
    logic [SUM_W-1:0] frame_sums_reg [NUM_CH];
    frame_time_t      frame_time_reg;

    logic             is_last;
    logic             accept;
    logic [SUM_W-1:0] sample_ext;

    assign is_last = (pos_reg == POS_LAST);
    assign in_ready = !is_last || !frame_valid_reg || frame_ready;
    assign accept = in_valid && in_ready;
    assign sample_ext = SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ch_reg <= '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                sums_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            if (is_last)
            begin
                pos_reg <= '0;
                ch_reg <= '0;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sums_reg[c] <= '0;
                end
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
                ch_reg <= (ch_reg == CH_LAST) ? '0 : ch_reg + 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (ch_reg == CH_W'(c))
                    begin
                        sums_reg[c] <= sums_reg[c] + sample_ext;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else if (accept && is_last)
        begin
            frame_valid_reg <= 1'b1;
        end
        else if (frame_ready)
        begin
            frame_valid_reg <= 1'b0;
        end
    end

    // last sample of a frame always belongs to the force channel
    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            for (int c = 0; c < NUM_CH - 1; c++)
            begin
                frame_sums_reg[c] <= sums_reg[c];
            end
            frame_sums_reg[NUM_CH-1] <= sums_reg[NUM_CH-1] + sample_ext;
            frame_time_reg.sample_time <= sample_time;
            frame_time_reg.elapsed <= sample_time - last_beat_time;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_sums = frame_sums_reg;
    assign frame_time = frame_time_reg;

    `DSD_ASSERT_NEXT_CYCLE(a_frame_wrap, accept && is_last,
        frame_valid_reg && pos_reg == '0 && ch_reg == '0)
    `DSD_ASSERT_SAME_CYCLE(a_lane_on_last, is_last, ch_reg == CH_LAST)

endmodule

@@ sv/dsd_calib.sv @@
// ----------------------------------------------------------------------------
// dsd_calib
// channel averaging and q16 calibration pipeline, beat distance on the side
// ----------------------------------------------------------------------------
module dsd_calib
    import dsd_pkg::*;
#(
    parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int SUM_W = sum_width(SAMPLES_PER_CHANNEL, SAMPLE_BITS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    frame_valid,
    output logic                    frame_ready,
    input  logic [SUM_W-1:0]        frame_sums [NUM_CH],
    input  frame_time_t             frame_time,
    output logic                    cal_valid,
    input  logic                    cal_ready,
    output logic signed [CAL_W-1:0] cal [NUM_CH],
    output beat_info_t              beat_info
);

    // exact division by reciprocal multiply for sums below 2**SUM_W
    localparam int DIV_L = $clog2(SAMPLES_PER_CHANNEL);
    localparam int DIV_SH = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam longint RECIP_L =
        ((longint'(1) << DIV_SH) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int X_W = SAMPLE_BITS + 20;

    logic                          va_reg;
    logic                          vb_reg;
    logic                          vc_reg;
    logic                          adv_a;
    logic                          adv_b;
    logic                          adv_c;

    logic [PROD_W-1:0]             prod [NUM_CH];
    logic [SAMPLE_BITS-1:0]        avg_reg [NUM_CH];
    logic signed [X_W-1:0]         x_next [NUM_CH];
    logic signed [X_W-1:0]         x_reg [NUM_CH];
    logic signed [X_W-1:0]         q_full [NUM_CH];
    logic signed [CAL_W-1:0]       cal_next [NUM_CH];
    logic signed [CAL_W-1:0]       cal_reg [NUM_CH];

    logic [PERIOD_W-1:0]           half_period;
    beat_info_t                    info_next;
    beat_info_t                    info_a_reg;
    beat_info_t                    info_b_reg;
    beat_info_t                    info_c_reg;

    assign adv_c = !vc_reg || cal_ready;
    assign adv_b = !vb_reg || adv_c;
    assign adv_a = !va_reg || adv_b;
    assign frame_ready = adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                va_reg <= frame_valid;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
            if (adv_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_comb
    begin
        half_period = cfg.beat_period >> 1;
        info_next.sample_time = frame_time.sample_time;
        info_next.early_side = frame_time.elapsed > TIME_W'(half_period);
        info_next.beat_offset = info_next.early_side ?
            TIME_W'(cfg.beat_period) - frame_time.elapsed : frame_time.elapsed;
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod[c] = PROD_W'(frame_sums[c]) * PROD_W'(RECIP);
            x_next[c] = X_W'($signed({1'b0, avg_reg[c]})) * X_W'(GAIN_Q16[c])
                        - X_W'(OFFS_Q16[c]);
            // truncate toward zero, then clamp to the 9 bit range
            q_full[c] = (x_reg[c] + (x_reg[c][X_W-1] ? X_W'(Q16_BIAS) : X_W'(0)))
                        >>> Q16_SHIFT;
            if (&q_full[c][X_W-1:CAL_W-1] || ~|q_full[c][X_W-1:CAL_W-1])
            begin
                cal_next[c] = q_full[c][CAL_W-1:0];
            end
            else
            begin
                cal_next[c] = q_full[c][X_W-1] ? CAL_MIN : CAL_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                avg_reg[c] <= prod[c][DIV_SH +: SAMPLE_BITS];
            end
            info_a_reg <= info_next;
        end
        if (adv_b)
        begin
            x_reg <= x_next;
            info_b_reg <= info_a_reg;
        end
        if (adv_c)
        begin
            cal_reg <= cal_next;
            info_c_reg <= info_b_reg;
        end
    end

    assign cal_valid = vc_reg;
    assign cal = cal_reg;
    assign beat_info = info_c_reg;

endmodule

@@ sv/dsd_strike.sv @@
// ----------------------------------------------------------------------------
// dsd_strike
// pad level, strike decision with holdoff and the result register
// ----------------------------------------------------------------------------
`include "drum_strike_detector_assert.svh"

module dsd_strike
    import dsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    cal_valid,
    output logic                    cal_ready,
    input  logic signed [CAL_W-1:0] cal [NUM_CH],
    input  beat_info_t              beat_info,
    dsd_out_if.source               result_out
);

    localparam int SUM4_W = CAL_W + 2;

    logic                    lv_valid_reg;
    logic signed [CAL_W-1:0] cal_l_reg [NUM_CH];
    logic [LEVEL_W-1:0]      level_reg;
    beat_info_t              info_l_reg;

    logic                    out_valid_reg;
    logic signed [CAL_W-1:0] cal_o_reg [NUM_CH];
    logic [LEVEL_W-1:0]      level_o_reg;
    logic                    strike_reg;
    logic                    early_reg;
    logic [TIME_W-1:0]       offset_reg;

    logic [LEVEL_W-1:0]      prev_level_reg;
    logic [TIME_W-1:0]       last_strike_reg;

    logic                    adv_o;
    logic                    adv_l;
    logic                    out_load;
    logic signed [SUM4_W-1:0] sum4;
    logic signed [SUM4_W-1:0] avg4;
    logic [LEVEL_W-1:0]      level_next;
    logic                    rise_ok;
    logic                    hold_ok;
    logic                    strike_next;

    assign adv_o = !out_valid_reg || result_out.ready;
    assign adv_l = !lv_valid_reg || adv_o;
    assign cal_ready = adv_l;
    assign out_load = lv_valid_reg && adv_o;

    // floor division by four of the position channel sum
    always_comb
    begin
        sum4 = SUM4_W'(cal[CH_TOP]) + SUM4_W'(cal[CH_BOTTOM])
               + SUM4_W'(cal[CH_LEFT]) + SUM4_W'(cal[CH_RIGHT]);
        avg4 = sum4 >>> 2;
        if (avg4 < $signed({3'b000, cfg.floor_level}))
        begin
            level_next = '0;
        end
        else
        begin
            level_next = avg4[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        rise_ok = (level_reg > prev_level_reg)
                  && ((level_reg - prev_level_reg) > cfg.rise_threshold);
        hold_ok = (info_l_reg.sample_time - last_strike_reg)
                  > TIME_W'(cfg.holdoff_ticks);
        strike_next = rise_ok && hold_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_level_reg <= '0;
            last_strike_reg <= '0;
        end
        else
        begin
            if (adv_l)
            begin
                lv_valid_reg <= cal_valid;
            end
            if (adv_o)
            begin
                out_valid_reg <= lv_valid_reg;
            end
            if (out_load)
            begin
                prev_level_reg <= level_reg;
                if (strike_next)
                begin
                    last_strike_reg <= info_l_reg.sample_time;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_l)
        begin
            cal_l_reg <= cal;
            level_reg <= level_next;
            info_l_reg <= beat_info;
        end
        if (adv_o)
        begin
            cal_o_reg <= cal_l_reg;
            level_o_reg <= level_reg;
            strike_reg <= strike_next;
            early_reg <= strike_next && info_l_reg.early_side;
            offset_reg <= strike_next ? info_l_reg.beat_offset : '0;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.top = cal_o_reg[CH_TOP];
    assign result_out.bottom = cal_o_reg[CH_BOTTOM];
    assign result_out.left = cal_o_reg[CH_LEFT];
    assign result_out.right = cal_o_reg[CH_RIGHT];
    assign result_out.force_res = cal_o_reg[CH_FORCE];
    assign result_out.level = level_o_reg;
    assign result_out.strike = strike_reg;
    assign result_out.early = early_reg;
    assign result_out.time_offset = offset_reg;

    `DSD_ASSERT_SAME_CYCLE(a_strike_has_level, out_valid_reg && strike_reg,
        level_o_reg != '0)
    `DSD_ASSERT_SAME_CYCLE(a_quiet_without_strike, out_valid_reg && !strike_reg,
        !early_reg && offset_reg == '0)
    `DSD_ASSERT_NEXT_CYCLE(a_prev_level_follows, out_load,
        prev_level_reg == level_o_reg)

endmodule

@@ sv/drum_strike_detector.sv @@
// ----------------------------------------------------------------------------
// drum_strike_detector
// pad sensor frame calibration and strike timing against a metronome
// ----------------------------------------------------------------------------
// Takes one raw sample per cycle, channels interleaved top, bottom, left,
// right, force, SAMPLES_PER_CHANNEL samples of each per frame. Only the last
// sample of a frame yields a result transaction: five calibrated values, the
// floored pad level, a strike flag and the early flag and distance to the
// nearer beat. Throughput is one sample per clock, set by the per channel
// accumulator; a result passes through the frame register, which loads with
// the frame's last sample, then the average, gain multiply, clamp, level and
// decision stages before it is valid at the output. Back pressure on the
// result side stalls the input only when the pipeline is full at a frame end.
// The user writes configuration registers through cfg_we/cfg_index/cfg_wdata
// only while no frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module drum_strike_detector
    import dsd_pkg::*;
#(
    parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dsd_in_if.sink                sample_in,
    dsd_out_if.source             result_out
);

    localparam int SUM_W = sum_width(SAMPLES_PER_CHANNEL, SAMPLE_BITS);

    cfg_t                    cfg_reg;

    logic                    frame_valid;
    logic                    frame_ready;
    logic [SUM_W-1:0]        frame_sums [NUM_CH];
    frame_time_t             frame_time;
    logic                    cal_valid;
    logic                    cal_ready;
    logic signed [CAL_W-1:0] cal [NUM_CH];
    beat_info_t              beat_info;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_level <= FLOOR_RESET;
            cfg_reg.rise_threshold <= RISE_RESET;
            cfg_reg.holdoff_ticks <= HOLDOFF_RESET;
            cfg_reg.beat_period <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLOOR_LEVEL:    cfg_reg.floor_level <= cfg_wdata[FLOOR_W-1:0];
                CFG_RISE_THRESHOLD: cfg_reg.rise_threshold <= cfg_wdata[RISE_W-1:0];
                CFG_HOLDOFF_TICKS:  cfg_reg.holdoff_ticks <= cfg_wdata[HOLDOFF_W-1:0];
                CFG_BEAT_PERIOD:    cfg_reg.beat_period <= cfg_wdata[PERIOD_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    dsd_frame_acc #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_frame_acc (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(sample_in.valid),
        .in_ready(sample_in.ready),
        .sample(sample_in.raw_sample),
        .sample_time(sample_in.sample_time),
        .last_beat_time(sample_in.last_beat_time),
        .frame_valid(frame_valid),
        .frame_ready(frame_ready),
        .frame_sums(frame_sums),
        .frame_time(frame_time)
    );

    dsd_calib #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_calib (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .frame_valid(frame_valid),
        .frame_ready(frame_ready),
        .frame_sums(frame_sums),
        .frame_time(frame_time),
        .cal_valid(cal_valid),
        .cal_ready(cal_ready),
        .cal(cal),
        .beat_info(beat_info)
    );

    dsd_strike u_strike (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .cal_valid(cal_valid),
        .cal_ready(cal_ready),
        .cal(cal),
        .beat_info(beat_info),
        .result_out(result_out)
    );

endmodule
